// ===== src/sequence_ack_window_tracker_macros.svh =====
// Assertion macros for the sequence acknowledgement window tracker.
// No dependencies; included by the files that carry assertions.
`ifndef SEQUENCE_ACK_WINDOW_TRACKER_MACROS_SVH
`define SEQUENCE_ACK_WINDOW_TRACKER_MACROS_SVH

// Check that a condition implies another in the same cycle
`define SAWT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the next cycle
`define SAWT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/sawt_pkg.sv =====
// Package for the sequence acknowledgement window tracker: request and
// result types, entry layout and fixed constants. No dependencies.
package sawt_pkg;

  localparam int unsigned SEQ_W     = 8;
  localparam int unsigned MASK_W    = 32;
  localparam int unsigned LINK_W    = 4;
  localparam int unsigned FLOOR_W   = 4;
  localparam int unsigned WINDOW    = 32;
  localparam int unsigned DROP_SPAN = 15;

  localparam logic [FLOOR_W-1:0] LOSS_FLOOR_RESET = 4'd2;

  typedef enum logic {
    MODE_PACKET = 1'b0,
    MODE_FORGET = 1'b1
  } mode_t;

  typedef struct packed {
    logic              mode;
    logic [LINK_W-1:0] link_index;
    logic              seq_valid;
    logic [SEQ_W-1:0]  sender_sequence;
  } req_t;

  typedef struct packed {
    logic [SEQ_W-1:0]   last_sequence;
    logic [MASK_W-1:0]  receive_mask;
    logic               entry_active;
    logic               late_packet;
    logic [SEQ_W-1:0]   missed_count;
    logic [FLOOR_W-1:0] loss_rate;
  } rsp_t;

  // One stored link entry
  typedef struct packed {
    logic              active;
    logic [MASK_W-1:0] mask;
    logic [SEQ_W-1:0]  seq;
  } entry_t;

endpackage

// ===== src/sequence_ack_window_tracker.sv =====
// Sequence acknowledgement window tracker, top level.
// Depends on sawt_pkg and sequence_ack_window_tracker_macros.svh.
//
//   channel | direction | handshake                 | payload
//   in      | input     | in_valid / in_stall       | in_req  (sawt_pkg::req_t)
//   out     | output    | out_valid / out_stall     | out_rsp (sawt_pkg::rsp_t)
//   cfg     | input     | cfg_wr_en, no wait        | cfg_wr_data (loss floor)
//
// A request is handled in order: the entry memory read is registered on
// acceptance, then update, write-back and result register load follow in
// the update state. After reset a clearing pass zeroes every entry; no
// request is accepted during it. A stalled result holds the update
// cycle, and with it the write-back, until the result register frees.
`include "sequence_ack_window_tracker_macros.svh"

module sequence_ack_window_tracker #(
  parameter int unsigned LINK_ENTRIES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  sawt_pkg::req_t                in_req,
  output logic                          out_valid,
  input  logic                          out_stall,
  output sawt_pkg::rsp_t                out_rsp,
  input  logic                          cfg_wr_en,
  input  logic [sawt_pkg::FLOOR_W-1:0]  cfg_wr_data
);

  import sawt_pkg::*;

  localparam int unsigned IDX_W = (LINK_ENTRIES > 1) ? $clog2(LINK_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LINK_ENTRIES - 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } state_t;

  state_t             state;
  logic [IDX_W-1:0]   clr_addr;
  req_t               req;
  logic [IDX_W-1:0]   req_idx;
  logic [FLOOR_W-1:0] loss_floor;

  entry_t             mem [LINK_ENTRIES];
  entry_t             rd_word;

  logic               in_accept;
  logic [IDX_W-1:0]   in_idx;
  logic               out_free;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  entry_t             mem_wdata;

  entry_t             upd_word;
  logic               upd_late;
  logic [SEQ_W-1:0]   upd_missed;
  logic [SEQ_W-1:0]   behind;
  logic [SEQ_W-1:0]   dist_m1;
  logic [MASK_W-1:0]  shifted;
  logic [FLOOR_W-1:0] ones;
  logic [FLOOR_W-1:0] drop_raw;
  rsp_t               rsp_next;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // Fold the link index onto the entries present
  always_comb begin
    in_idx = '0;
    for (int i = 0; i < (1 << LINK_W); i++) begin
      if (in_req.link_index == LINK_W'(i)) begin
        in_idx = IDX_W'(i % LINK_ENTRIES);
      end
    end
  end

  // Hold the loss floor register
  always_ff @(posedge clk) begin
    if (rst) begin
      loss_floor <= LOSS_FLOOR_RESET;
    end else if (cfg_wr_en) begin
      loss_floor <= cfg_wr_data;
    end
  end

  // Update the entry read for the current request
  always_comb begin
    upd_word   = rd_word;
    upd_late   = 1'b0;
    upd_missed = '0;
    behind     = rd_word.seq - SEQ_W'(1) - req.sender_sequence;
    dist_m1    = req.sender_sequence - rd_word.seq - SEQ_W'(1);
    shifted    = {rd_word.mask[MASK_W-2:0], 1'b1};
    if (req.mode == MODE_FORGET) begin
      upd_word.active = 1'b0;
      upd_word.mask   = '0;
    end else if (req.seq_valid) begin
      if (!rd_word.active) begin
        upd_word.active = 1'b1;
        upd_word.seq    = req.sender_sequence;
      end else if (behind < SEQ_W'(WINDOW)) begin
        upd_word.mask = rd_word.mask | (MASK_W'(1) << behind[4:0]);
        upd_late      = 1'b1;
      end else begin
        // Advance the window; a repeated sequence wraps to a full turn
        upd_word.mask = (dist_m1 < SEQ_W'(WINDOW)) ? (shifted << dist_m1[4:0]) : '0;
        upd_word.seq  = req.sender_sequence;
        upd_missed    = dist_m1;
      end
    end
  end

  // Build the result from the updated entry
  always_comb begin
    ones     = FLOOR_W'($countones(upd_word.mask[DROP_SPAN-1:0]));
    drop_raw = FLOOR_W'(DROP_SPAN) - ones;
    rsp_next.last_sequence = upd_word.active ? upd_word.seq : '0;
    rsp_next.receive_mask  = upd_word.mask;
    rsp_next.entry_active  = upd_word.active;
    rsp_next.late_packet   = upd_late;
    rsp_next.missed_count  = upd_missed;
    rsp_next.loss_rate     = (drop_raw <= loss_floor) ? '0 : drop_raw;
  end

  // Select the memory write: clearing pass or write-back
  always_comb begin
    mem_we    = (state == ST_CLEAR) || ((state == ST_UPDATE) && out_free);
    mem_waddr = (state == ST_CLEAR) ? clr_addr : req_idx;
    mem_wdata = (state == ST_CLEAR) ? '0 : upd_word;
  end

  // Entry memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (in_accept) begin
      rd_word <= mem[in_idx];
    end
  end

  // Sequence the clearing pass, requests and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      // Load a fresh result, or drop the one just taken
      if ((state == ST_UPDATE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + IDX_W'(1);
          if (clr_addr == LAST_IDX) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_accept) begin
            req     <= in_req;
            req_idx <= in_idx;
            state   <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (out_free) begin
            out_rsp <= rsp_next;
            state   <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

  `SAWT_ASSERT_NEXT(a_accept_to_update, clk, rst, in_accept, state == ST_UPDATE, "no update")
  `SAWT_ASSERT_SAME(a_result_from_update, clk, rst, $rose(out_valid), $past(state) == ST_UPDATE, "stray result")
  `SAWT_ASSERT_NEXT(a_writeback_matches, clk, rst, (state == ST_UPDATE) && out_free, out_rsp.receive_mask == $past(mem_wdata.mask), "mask differs")
  `SAWT_ASSERT_NEXT(a_clear_advances, clk, rst, (state == ST_CLEAR) && (clr_addr != LAST_IDX), clr_addr == $past(clr_addr) + IDX_W'(1), "clear skipped")

endmodule
